FILE: src/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants for the array intersection probe
// List depth, field widths, action and result codes, and the result and
// memory request records passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 11;
  localparam int ACTION_W   = 2;

  localparam int OUT_FIELDS_W = VALUE_W + 1 + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 11'd1024;

  localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PROBE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUT
  } state_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               verdict;
    logic [COUNT_W-1:0] total;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: src/aip_list_mem.sv
// ----------------------------------------------------------------------------
// aip_list_mem: second-list storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_list_mem (
  input  wire logic                      clk,
  input  wire aip_pkg::mem_req_t         req,
  output logic [aip_pkg::VALUE_W-1:0]    rdata
);
  import aip_pkg::*;

  logic [VALUE_W-1:0] mem [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/aip_out_reg.sv
// ----------------------------------------------------------------------------
// aip_out_reg: result output register
// Holds one result beat towards the master side; refills on the beat it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               push_ready,
  input  wire aip_pkg::res_t push_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output aip_pkg::res_t      out_data
);
  import aip_pkg::*;

  assign push_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_ready) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      out_data <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/array_intersection_probe.sv
// ----------------------------------------------------------------------------
// array_intersection_probe: nested-loop list intersection
// Stores the second list in a RAM, scans it serially for each probe beat and
// emits matches, overflow and finish verdicts through an output register.
// ----------------------------------------------------------------------------
// Store writes the RAM; action 3 is accepted and ignored. Finish passes through
//   S_PUT to the output register. Probe: one RAM read and compare per cycle over
//   the stored entries, then S_PUT hands the result over; a probe with an empty
//   list or after overflow is accepted and ignored.
// Reset (rst, synchronous): list length, match count and overflow clear,
//   capacity returns to 1024, output empty; RAM contents are not cleared.
`default_nettype none

module array_intersection_probe (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [aip_pkg::COUNT_W-1:0]  cfg_wdata,    // result_capacity
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [aip_pkg::VALUE_W-1:0]  s_tdata,      // [31:0] value
  input  wire logic [aip_pkg::ACTION_W-1:0] s_tuser,      // [1:0] action
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [aip_pkg::OUT_TDATA_W-1:0]   m_tdata,      // [31:0] match_value,
                                                          // [32] verdict,
                                                          // [43:33] match_total
  output logic                              m_tuser       // [0] kind
);
  import aip_pkg::*;

  state_t             state, state_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [COUNT_W-1:0] emitted, emitted_next;
  logic               ovf, ovf_next;
  logic [COUNT_W-1:0] capacity;
  logic [VALUE_W-1:0] probe, probe_next;
  logic [ADDR_W-1:0]  cmp_idx, cmp_idx_next;
  res_t               res, res_next;

  mem_req_t           mem_req;
  logic [VALUE_W-1:0] rdata;
  logic               res_push, push_ready;
  res_t               out_res;
  logic               in_beat, scan_last;

  aip_list_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  aip_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_ready (push_ready),
    .push_data  (res),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_res)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res.total, out_res.verdict, out_res.value};

  assign in_beat   = s_tvalid && s_tready;
  assign scan_last = (LEN_W'(cmp_idx) + LEN_W'(1)) == len;

  always_comb begin
    state_next   = state;
    len_next     = len;
    emitted_next = emitted;
    ovf_next     = ovf;
    probe_next   = probe;
    cmp_idx_next = cmp_idx;
    res_next     = res;
    s_tready     = 1'b0;
    res_push     = 1'b0;
    mem_req      = '0;
    mem_req.wdata = s_tdata;
    mem_req.waddr = len[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (in_beat) begin
          case (s_tuser)
            ACT_STORE: begin
              if (len != LEN_W'(LIST_DEPTH)) begin
                mem_req.we = 1'b1;
                len_next   = len + LEN_W'(1);
              end
            end
            ACT_PROBE: begin
              if (!ovf && len != '0) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                probe_next    = s_tdata;
                cmp_idx_next  = '0;
                state_next    = S_SCAN;
              end
            end
            ACT_FINISH: begin
              res_next.kind    = KIND_VERDICT;
              res_next.value   = '0;
              res_next.verdict = (emitted != '0) && !ovf;
              res_next.total   = emitted;
              len_next         = '0;
              emitted_next     = '0;
              ovf_next         = 1'b0;
              state_next       = S_PUT;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rdata == probe) begin
          // first matching entry ends the scan, duplicates never emit twice
          if (emitted < capacity) begin
            emitted_next     = emitted + COUNT_W'(1);
            res_next.kind    = KIND_MATCH;
            res_next.value   = probe;
            res_next.verdict = 1'b0;
            res_next.total   = emitted + COUNT_W'(1);
          end else begin
            ovf_next         = 1'b1;
            res_next.kind    = KIND_VERDICT;
            res_next.value   = '0;
            res_next.verdict = 1'b0;
            res_next.total   = emitted;
          end
          state_next = S_PUT;
        end else if (scan_last) begin
          state_next = S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cmp_idx + ADDR_W'(1);
          cmp_idx_next  = cmp_idx + ADDR_W'(1);
        end
      end

      S_PUT: begin
        res_push = 1'b1;
        if (push_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      emitted  <= '0;
      ovf      <= 1'b0;
      capacity <= CAPACITY_RESET;
    end else begin
      state   <= state_next;
      len     <= len_next;
      emitted <= emitted_next;
      ovf     <= ovf_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe   <= probe_next;
    cmp_idx <= cmp_idx_next;
    res     <= res_next;
  end

  // scan only runs over a non-empty list and stays inside it
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> len != '0)
    else $error("scan with empty list");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> LEN_W'(cmp_idx) < len)
    else $error("scan index past list length");

  // overflow is always announced by a verdict beat
  a_ovf_verdict: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> state == S_PUT && res.kind == KIND_VERDICT)
    else $error("overflow set without verdict result");

  // match count moves only on an emitted match or a finish clear
  a_count_move: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && emitted != $past(emitted) |->
      emitted == '0 || (state == S_PUT && res.kind == KIND_MATCH && res.total == emitted))
    else $error("match count changed unexpectedly");

endmodule

`default_nettype wire
